// File: rtl/core/xs256_pkg.sv
package xs256_pkg;

   // Word geometry
   localparam int WORD_W    = 64;
   localparam int HALF_W    = WORD_W / 2;
   localparam int NUM_WORDS = 4;
   localparam int IDX_W     = $clog2(NUM_WORDS);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [HALF_W-1:0] half_type;
   typedef logic [IDX_W-1:0]  index_type;

   // Item kinds
   typedef enum logic {
      KIND_RESEED = 1'b0,
      KIND_DRAW   = 1'b1
   } kind_type;

   // Seed expansion constants
   localparam word_type GOLDEN_STEP = 64'h9e3779b97f4a7c15;
   localparam word_type MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
   localparam word_type MIX_MUL_B   = 64'h94d049bb133111eb;
   localparam int       MIX_SHIFT_A = 30;
   localparam int       MIX_SHIFT_B = 27;
   localparam int       MIX_SHIFT_C = 31;

   // Generator step constants
   localparam int STEP_SHIFT = 17;
   localparam int STEP_ROT   = 45;
   localparam int SCRAM_ROT  = 7;

   // State word write from the seeding sequencer
   typedef struct packed {
      logic      valid;
      index_type index;
      word_type  data;
   } word_wr_type;

   function automatic word_type rotl(input word_type v, input int amount);
      rotl = (v << amount) | (v >> (WORD_W - amount));
   endfunction

endpackage

// File: rtl/core/xs256_mul.sv
module xs256_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  xs256_pkg::word_type opnd_a,
   input  xs256_pkg::word_type opnd_b,
   output logic              done,
   output xs256_pkg::word_type result
);
   import xs256_pkg::*;

   // Low 64 bits of a 64x64 product from three 32x32 partial products:
   // lo*lo, then lo*hi and hi*lo folded into the upper half.
   logic       busy_ff;
   logic [1:0] step_ff;
   word_type   a_ff;
   word_type   b_ff;
   word_type   prod_ff;
   word_type   prod_in;
   word_type   sum_ff;
   logic       done_ff;
   half_type   mul_a;
   half_type   mul_b;

   // Partial product operand select
   always_comb begin
      unique case (step_ff)
         2'd0: begin
            mul_a = a_ff[HALF_W-1:0];
            mul_b = b_ff[HALF_W-1:0];
         end
         2'd1: begin
            mul_a = a_ff[HALF_W-1:0];
            mul_b = b_ff[WORD_W-1:HALF_W];
         end
         default: begin
            mul_a = a_ff[WORD_W-1:HALF_W];
            mul_b = b_ff[HALF_W-1:0];
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= opnd_a;
         b_ff <= opnd_b;
      end
      if (busy_ff) begin
         prod_ff <= prod_in;
         if (step_ff == 2'd1) begin
            sum_ff <= prod_ff;
         end else if (step_ff != 2'd0) begin
            sum_ff <= sum_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
         end
      end
   end

   assign done   = done_ff;
   assign result = sum_ff;

   // Checks
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("multiplier done without a pass");

endmodule

// File: rtl/core/xs256_seed_seq.sv
module xs256_seed_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  xs256_pkg::word_type    seed,
   output logic                   mul_start,
   output xs256_pkg::word_type    mul_opnd_a,
   output xs256_pkg::word_type    mul_opnd_b,
   input  logic                   mul_done,
   input  xs256_pkg::word_type    mul_result,
   output logic                   busy,
   output xs256_pkg::word_wr_type word_wr
);
   import xs256_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_A,
      S_WAIT_A,
      S_MUL_B,
      S_WAIT_B
   } state_type;

   state_type state_ff;
   word_type  acc_ff;
   index_type idx_ff;
   word_type  mixed;

   // Final xor-shift of the second product
   assign mixed = mul_result ^ (mul_result >> MIX_SHIFT_C);

   // Multiplier issue
   always_comb begin
      mul_start  = (state_ff == S_MUL_A) || (state_ff == S_MUL_B);
      if (state_ff == S_MUL_B) begin
         mul_opnd_a = acc_ff ^ (acc_ff >> MIX_SHIFT_B);
         mul_opnd_b = MIX_MUL_B;
      end else begin
         mul_opnd_a = acc_ff ^ (acc_ff >> MIX_SHIFT_A);
         mul_opnd_b = MIX_MUL_A;
      end
   end

   // Word write goes out as soon as the mix finishes
   assign word_wr.valid = (state_ff == S_WAIT_B) && mul_done;
   assign word_wr.index = idx_ff;
   assign word_wr.data  = mixed;
   assign busy          = (state_ff != S_IDLE);

   // Sequencer; reset runs the expansion of seed zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_MUL_A;
         acc_ff   <= GOLDEN_STEP;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  acc_ff   <= seed + GOLDEN_STEP;
                  idx_ff   <= '0;
                  state_ff <= S_MUL_A;
               end
            end
            S_MUL_A: state_ff <= S_WAIT_A;
            S_WAIT_A: begin
               if (mul_done) begin
                  acc_ff   <= mul_result;
                  state_ff <= S_MUL_B;
               end
            end
            S_MUL_B: state_ff <= S_WAIT_B;
            S_WAIT_B: begin
               if (mul_done) begin
                  acc_ff <= mixed;
                  if (idx_ff == index_type'(NUM_WORDS - 1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + index_type'(1);
                     state_ff <= S_MUL_A;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/xoshiro256ss_generator_top.sv
// xoshiro256** generator with splitmix-style seed expansion.
// Draw: result registered in the cycle after the transaction; one draw per
// cycle while the input is not stalled. Reseed: no result; eight 64-bit
// products through one shared 32x32 multiplier, three partial products per
// 64-bit product. Reset: synchronous; the block runs the expansion of seed
// zero (input stalled) before the first transaction is taken.
module xoshiro256ss_generator_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  xs256_pkg::word_type req_seed_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output xs256_pkg::word_type rsp_random_word
);
   import xs256_pkg::*;

   word_type    gen_ff [NUM_WORDS];
   logic        rsp_valid_ff;
   word_type    rsp_word_ff;
   logic        req_accept;
   logic        draw_accept;
   logic        reseed_accept;
   logic        seq_busy;
   word_wr_type word_wr;
   logic        mul_start;
   word_type    mul_opnd_a;
   word_type    mul_opnd_b;
   logic        mul_done;
   word_type    mul_result;
   word_type    scram_mid;
   word_type    scram_word;
   word_type    nxt0;
   word_type    nxt1;
   word_type    nxt2;
   word_type    nxt3;

   // Handshake
   assign req_stall     = seq_busy || (rsp_valid_ff && rsp_stall);
   assign req_accept    = req_valid && !req_stall;
   assign draw_accept   = req_accept && (kind_type'(req_kind) == KIND_DRAW);
   assign reseed_accept = req_accept && (kind_type'(req_kind) == KIND_RESEED);

   xs256_seed_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (reseed_accept),
      .seed       (req_seed_value),
      .mul_start  (mul_start),
      .mul_opnd_a (mul_opnd_a),
      .mul_opnd_b (mul_opnd_b),
      .mul_done   (mul_done),
      .mul_result (mul_result),
      .busy       (seq_busy),
      .word_wr    (word_wr)
   );

   xs256_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .opnd_a (mul_opnd_a),
      .opnd_b (mul_opnd_b),
      .done   (mul_done),
      .result (mul_result)
   );

   // Scrambler: rotl(s1 * 5, 7) * 9 as shift-adds
   assign scram_mid  = rotl(gen_ff[1] + (gen_ff[1] << 2), SCRAM_ROT);
   assign scram_word = scram_mid + (scram_mid << 3);

   // Linear state step
   always_comb begin
      nxt2 = gen_ff[2] ^ gen_ff[0];
      nxt3 = gen_ff[3] ^ gen_ff[1];
      nxt1 = gen_ff[1] ^ nxt2;
      nxt0 = gen_ff[0] ^ nxt3;
      nxt2 = nxt2 ^ (gen_ff[1] << STEP_SHIFT);
      nxt3 = rotl(nxt3, STEP_ROT);
   end

   // State words
   always_ff @(posedge clock) begin
      if (word_wr.valid) begin
         gen_ff[word_wr.index] <= word_wr.data;
      end else if (draw_accept) begin
         gen_ff[0] <= nxt0;
         gen_ff[1] <= nxt1;
         gen_ff[2] <= nxt2;
         gen_ff[3] <= nxt3;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (draw_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (draw_accept) begin
         rsp_word_ff <= scram_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   // Checks
   a_wr_only_seeding: assert property (@(posedge clock) disable iff (reset)
      word_wr.valid |-> seq_busy)
      else $error("state word written outside seeding");

   a_rsp_from_draw: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(draw_accept))
      else $error("result without a draw");

   a_reseed_busy: assert property (@(posedge clock) disable iff (reset)
      reseed_accept |=> seq_busy && !rsp_valid_ff || seq_busy)
      else $error("reseed did not start seeding");

endmodule
